/* sv/ppp_pkg.sv */
// Shared constants and types of the perspective point projector.
package ppp_pkg;

  localparam int COORD_BITS  = 21;
  localparam int TEX_DIM_MAX = 4096;

  localparam int DIM_W    = $clog2(TEX_DIM_MAX + 1);
  localparam int TEXREG_W = 13;
  localparam int ROW_W    = 48;
  localparam int ORG_W    = 63;
  localparam int FOC_W    = 20;
  localparam int PIX_W    = 16;
  localparam int IDX_W    = 24;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + 16;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DROP   = (COORD_BITS > 21) ? COORD_BITS - 21 : 0;
  localparam int CAM_W  = SUM_W - DROP;
  localparam int HALF   = CAM_W / 2;
  localparam int HI_W   = CAM_W - HALF + FOC_W + 1;
  localparam int NUM_W  = CAM_W + 22;
  localparam int DEN_W  = CAM_W + 8;
  localparam int QB     = 17;
  localparam int DIV_W  = NUM_W + QB;

  localparam logic [2:0] REG_ROT_X  = 3'd0;
  localparam logic [2:0] REG_ROT_Y  = 3'd1;
  localparam logic [2:0] REG_ROT_Z  = 3'd2;
  localparam logic [2:0] REG_ORIGIN = 3'd3;
  localparam logic [2:0] REG_FOCAL  = 3'd4;
  localparam logic [2:0] REG_TEX_W  = 3'd5;
  localparam logic [2:0] REG_TEX_H  = 3'd6;

  typedef struct packed {
    logic signed [CAM_W-1:0] cx;
    logic signed [CAM_W-1:0] cy;
    logic signed [CAM_W-1:0] cz;
  } cam_t;

  typedef struct packed {
    logic             front;
    logic             neg_u;
    logic [NUM_W-1:0] mag_u;
    logic             neg_v;
    logic [NUM_W-1:0] mag_v;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [QB-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic     front;
    div_res_t u;
    div_res_t v;
  } div_out_t;

endpackage

/* sv/perspective_point_projector_top.sv */
// Top level of the perspective point projector: register file and pipeline chain.
//
// Usage: software loads the three rotation rows, the projector origin, the focal
// length and the texture size over the APB port (64-bit registers at 8-byte
// steps) while no transaction is in flight. World points then stream in on the
// s_axis channel, one per transaction; each yields exactly one result on m_axis.
// Results carry u, v and the bottom-up texel index in tdata, and the in-front and
// in-bounds flags in tuser.
// The chain runs origin subtraction and rotation, then focal scaling and numerator
// build, then the bit-per-stage divider (overflow check plus 17 quotient bits), and
// last saturation and the texel index multiply.
// Throughput is one point per cycle while the receiver accepts. Each stage holds
// its own valid bit and a stage loads whenever it is empty or the stage after it
// moves, so bubbles close up; when the receiver stalls, the pipeline fills behind
// the output register and s_axis_tready drops only once every stage holds a point.
// Reset clears the configuration registers to zero and empties the pipeline.
module perspective_point_projector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x, point_y, point_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pixel_u, pixel_v, texel_index
  output logic [1:0]  m_axis_tuser    // in_front, in_bounds
);
  import ppp_pkg::*;

  logic [ROW_W-1:0]    rot_x_q, rot_y_q, rot_z_q;
  logic [ORG_W-1:0]    origin_q;
  logic [FOC_W-1:0]    focal_q;
  logic [TEXREG_W-1:0] tex_w_q, tex_h_q;
  logic [2:0]          idx;
  logic                wr;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q  <= '0;
      rot_y_q  <= '0;
      rot_z_q  <= '0;
      origin_q <= '0;
      focal_q  <= '0;
      tex_w_q  <= '0;
      tex_h_q  <= '0;
    end else if (wr) begin
      case (idx)
        REG_ROT_X:  rot_x_q  <= pwdata[ROW_W-1:0];
        REG_ROT_Y:  rot_y_q  <= pwdata[ROW_W-1:0];
        REG_ROT_Z:  rot_z_q  <= pwdata[ROW_W-1:0];
        REG_ORIGIN: origin_q <= pwdata[ORG_W-1:0];
        REG_FOCAL:  focal_q  <= pwdata[FOC_W-1:0];
        REG_TEX_W:  tex_w_q  <= pwdata[TEXREG_W-1:0];
        REG_TEX_H:  tex_h_q  <= pwdata[TEXREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROT_X:  prdata = 64'(rot_x_q);
      REG_ROT_Y:  prdata = 64'(rot_y_q);
      REG_ROT_Z:  prdata = 64'(rot_z_q);
      REG_ORIGIN: prdata = 64'(origin_q);
      REG_FOCAL:  prdata = 64'(focal_q);
      REG_TEX_W:  prdata = 64'(tex_w_q);
      REG_TEX_H:  prdata = 64'(tex_h_q);
      default:    prdata = '0;
    endcase
  end

  logic [DIM_W-1:0] w_c, h_c;

  assign w_c = ({19'd0, tex_w_q} > 32'(TEX_DIM_MAX)) ? DIM_W'(TEX_DIM_MAX) : DIM_W'(tex_w_q);
  assign h_c = ({19'd0, tex_h_q} > 32'(TEX_DIM_MAX)) ? DIM_W'(TEX_DIM_MAX) : DIM_W'(tex_h_q);

  logic      rot_valid, rot_ready, scl_valid, scl_ready, div_valid, div_ready, fin_ready;
  cam_t      cam;
  div_in_t   div_in;
  div_out_t  div_res;
  logic      in_front, in_bounds;
  logic [PIX_W-1:0] pixel_u, pixel_v;
  logic [IDX_W-1:0] texel_index;

  ppp_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .point_i  (s_axis_tdata[3*COORD_BITS-1:0]),
    .origin_i (origin_q),
    .row_x_i  (rot_x_q),
    .row_y_i  (rot_y_q),
    .row_z_i  (rot_z_q),
    .valid_o  (rot_valid),
    .ready_i  (rot_ready),
    .cam_o    (cam)
  );

  ppp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .cam_i   (cam),
    .focal_i (focal_q),
    .w_i     (w_c),
    .h_i     (h_c),
    .valid_o (scl_valid),
    .ready_i (scl_ready),
    .div_o   (div_in)
  );

  ppp_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .ready_o (scl_ready),
    .div_i   (div_in),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .res_o   (div_res)
  );

  ppp_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (div_valid),
    .ready_o       (fin_ready),
    .res_i         (div_res),
    .w_i           (w_c),
    .h_i           (h_c),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .in_front_o    (in_front),
    .in_bounds_o   (in_bounds),
    .pixel_u_o     (pixel_u),
    .pixel_v_o     (pixel_v),
    .texel_index_o (texel_index)
  );

  assign div_ready    = fin_ready;
  assign m_axis_tdata = {texel_index, pixel_v, pixel_u};
  assign m_axis_tuser = {in_bounds, in_front};

endmodule

/* sv/ppp_rotate.sv */
// Origin subtraction and 3x3 rotation into camera space, three stages.
module ppp_rotate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [3*ppp_pkg::COORD_BITS-1:0]    point_i,
  input  logic [ppp_pkg::ORG_W-1:0]           origin_i,
  input  logic [ppp_pkg::ROW_W-1:0]           row_x_i,
  input  logic [ppp_pkg::ROW_W-1:0]           row_y_i,
  input  logic [ppp_pkg::ROW_W-1:0]           row_z_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output ppp_pkg::cam_t                       cam_o
);
  import ppp_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  logic [3*COORD_BITS-1:0] org_ext;
  logic [ROW_W-1:0]        rows [3];
  logic signed [DIFF_W-1:0] d_d [3];
  logic signed [DIFF_W-1:0] d_q [3];
  logic signed [PROD_W-1:0] p_d [3][3];
  logic signed [PROD_W-1:0] p_q [3][3];
  logic signed [SUM_W-1:0]  s   [3];
  cam_t cam_d, cam_q;

  assign org_ext = (3*COORD_BITS)'(origin_i);
  assign rows[0] = row_x_i;
  assign rows[1] = row_y_i;
  assign rows[2] = row_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k] = DIFF_W'($signed(point_i[k*COORD_BITS +: COORD_BITS]))
             - DIFF_W'($signed(org_ext[k*COORD_BITS +: COORD_BITS]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_d[r][c] = $signed(rows[r][16*c +: 16]) * d_q[c];
      end
    end
    for (int r = 0; r < 3; r++) begin
      s[r] = SUM_W'(p_q[r][0]) + SUM_W'(p_q[r][1]) + SUM_W'(p_q[r][2]);
    end
    cam_d.cx = CAM_W'(s[0] >>> DROP);
    cam_d.cy = CAM_W'(s[1] >>> DROP);
    cam_d.cz = CAM_W'(s[2] >>> DROP);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) d_q <= d_d;
    if (en[1]) p_q <= p_d;
    if (en[2]) cam_q <= cam_d;
  end

  assign cam_o = cam_q;

endmodule

/* sv/ppp_scale.sv */
// Focal scaling, numerator build and sign split ahead of the divider, four stages.
module ppp_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  ppp_pkg::cam_t                cam_i,
  input  logic [ppp_pkg::FOC_W-1:0]    focal_i,
  input  logic [ppp_pkg::DIM_W-1:0]    w_i,
  input  logic [ppp_pkg::DIM_W-1:0]    h_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ppp_pkg::div_in_t             div_o
);
  import ppp_pkg::*;

  localparam int NS = 4;
  localparam int WZ_W = DIM_W + CAM_W;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  // stage a: partial products
  logic                        front_a_d, front_a_q;
  logic [DEN_W-1:0]            den_a_d, den_a_q;
  logic [HALF+FOC_W-1:0]       xlo_a_d, xlo_a_q, ylo_a_d, ylo_a_q;
  logic signed [HI_W-1:0]      xhi_a_d, xhi_a_q, yhi_a_d, yhi_a_q;
  logic [WZ_W-1:0]             wz_a_d, wz_a_q, hz_a_d, hz_a_q;
  // stage b: recombined focal products
  logic                        front_b_q;
  logic [DEN_W-1:0]            den_b_q;
  logic signed [NUM_W-1:0]     xf_b_d, xf_b_q, yf_b_d, yf_b_q;
  logic [WZ_W-1:0]             wz_b_q, hz_b_q;
  // stage c: numerators
  logic                        front_c_q;
  logic [DEN_W-1:0]            den_c_q;
  logic signed [NUM_W-1:0]     nu_c_d, nu_c_q, nv_c_d, nv_c_q;
  // stage d: magnitude and sign
  div_in_t                     div_d, div_q;

  always_comb begin
    front_a_d = ~cam_i.cz[CAM_W-1] & (cam_i.cz != '0);
    den_a_d   = {cam_i.cz, 8'd0};
    xlo_a_d   = (HALF+FOC_W)'(cam_i.cx[HALF-1:0]) * (HALF+FOC_W)'(focal_i);
    ylo_a_d   = (HALF+FOC_W)'(cam_i.cy[HALF-1:0]) * (HALF+FOC_W)'(focal_i);
    xhi_a_d   = $signed(cam_i.cx[CAM_W-1:HALF]) * $signed({1'b0, focal_i});
    yhi_a_d   = $signed(cam_i.cy[CAM_W-1:HALF]) * $signed({1'b0, focal_i});
    wz_a_d    = WZ_W'(w_i) * WZ_W'($unsigned(cam_i.cz));
    hz_a_d    = WZ_W'(h_i) * WZ_W'($unsigned(cam_i.cz));

    xf_b_d = (NUM_W'(xhi_a_q) <<< HALF) + $signed(NUM_W'(xlo_a_q));
    yf_b_d = (NUM_W'(yhi_a_q) <<< HALF) + $signed(NUM_W'(ylo_a_q));

    nu_c_d = $signed(NUM_W'(wz_b_q) << 7) + xf_b_q;
    nv_c_d = $signed(NUM_W'(hz_b_q) << 7) - yf_b_q;

    div_d.front = front_c_q;
    div_d.den   = den_c_q;
    div_d.neg_u = nu_c_q[NUM_W-1];
    div_d.mag_u = nu_c_q[NUM_W-1] ? NUM_W'(-nu_c_q) : NUM_W'(nu_c_q);
    div_d.neg_v = nv_c_q[NUM_W-1];
    div_d.mag_v = nv_c_q[NUM_W-1] ? NUM_W'(-nv_c_q) : NUM_W'(nv_c_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_a_q <= front_a_d;
      den_a_q   <= den_a_d;
      xlo_a_q   <= xlo_a_d;
      ylo_a_q   <= ylo_a_d;
      xhi_a_q   <= xhi_a_d;
      yhi_a_q   <= yhi_a_d;
      wz_a_q    <= wz_a_d;
      hz_a_q    <= hz_a_d;
    end
    if (en[1]) begin
      front_b_q <= front_a_q;
      den_b_q   <= den_a_q;
      xf_b_q    <= xf_b_d;
      yf_b_q    <= yf_b_d;
      wz_b_q    <= wz_a_q;
      hz_b_q    <= hz_a_q;
    end
    if (en[2]) begin
      front_c_q <= front_b_q;
      den_c_q   <= den_b_q;
      nu_c_q    <= nu_c_d;
      nv_c_q    <= nv_c_d;
    end
    if (en[3]) div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

/* sv/ppp_divider.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage, with overflow check.
module ppp_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ppp_pkg::div_in_t     div_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ppp_pkg::div_out_t    res_o
);
  import ppp_pkg::*;

  localparam int NS = QB + 1;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  div_out_t         info_q  [NS];
  logic [NUM_W-1:0] rem_u_q [NS];
  logic [NUM_W-1:0] rem_v_q [NS];
  logic [DEN_W-1:0] den_q   [NS];

  div_out_t info0_d;

  always_comb begin
    info0_d.front = div_i.front;
    info0_d.u.neg = div_i.neg_u;
    info0_d.u.ovf = DIV_W'(div_i.mag_u) >= (DIV_W'(div_i.den) << QB);
    info0_d.u.quo = '0;
    info0_d.v.neg = div_i.neg_v;
    info0_d.v.ovf = DIV_W'(div_i.mag_v) >= (DIV_W'(div_i.den) << QB);
    info0_d.v.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      info_q[0]  <= info0_d;
      rem_u_q[0] <= div_i.mag_u;
      rem_v_q[0] <= div_i.mag_v;
      den_q[0]   <= div_i.den;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam int I = QB - j;
    logic [DIV_W-1:0] sh, ru, rv;
    logic             geu, gev;
    div_out_t         info_d;
    logic [NUM_W-1:0] rem_u_d, rem_v_d;

    always_comb begin
      sh  = DIV_W'(den_q[j-1]) << I;
      ru  = DIV_W'(rem_u_q[j-1]);
      rv  = DIV_W'(rem_v_q[j-1]);
      geu = ru >= sh;
      gev = rv >= sh;
      rem_u_d = geu ? NUM_W'(ru - sh) : rem_u_q[j-1];
      rem_v_d = gev ? NUM_W'(rv - sh) : rem_v_q[j-1];
      info_d = info_q[j-1];
      info_d.u.quo[I] = geu;
      info_d.v.quo[I] = gev;
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        info_q[j]  <= info_d;
        rem_u_q[j] <= rem_u_d;
        rem_v_q[j] <= rem_v_d;
        den_q[j]   <= den_q[j-1];
      end
    end
  end

  assign res_o = info_q[NS-1];

endmodule

/* sv/ppp_finish.sv */
// Sign, saturation, bounds test and texel index, ending in the output register.
module ppp_finish (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  ppp_pkg::div_out_t            res_i,
  input  logic [ppp_pkg::DIM_W-1:0]    w_i,
  input  logic [ppp_pkg::DIM_W-1:0]    h_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic                         in_front_o,
  output logic                         in_bounds_o,
  output logic [ppp_pkg::PIX_W-1:0]    pixel_u_o,
  output logic [ppp_pkg::PIX_W-1:0]    pixel_v_o,
  output logic [ppp_pkg::IDX_W-1:0]    texel_index_o
);
  import ppp_pkg::*;

  localparam int NS = 2;
  localparam logic signed [QB:0] PMAX = (QB+1)'(32767);
  localparam logic signed [QB:0] PMIN = -(QB+1)'(32768);

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  function automatic logic [PIX_W-1:0] sat_pix(input logic ovf, input logic neg,
                                               input logic signed [QB:0] val);
    logic [PIX_W-1:0] r;
    if (ovf) r = neg ? 16'h8000 : 16'h7fff;
    else if (val > PMAX) r = 16'h7fff;
    else if (val < PMIN) r = 16'h8000;
    else r = val[PIX_W-1:0];
    return r;
  endfunction

  logic signed [QB:0] val_u, val_v, w_s, h_s;
  logic               ru, rv;
  logic               front_d, front_q, inb_d, inb_q;
  logic [PIX_W-1:0]   pu_d, pu_q, pv_d, pv_q;
  logic [DIM_W-1:0]   col_d, col_q, row_d, row_q;
  logic [IDX_W-1:0]   idx_d;

  always_comb begin
    val_u = res_i.u.neg ? -$signed({1'b0, res_i.u.quo}) : $signed({1'b0, res_i.u.quo});
    val_v = res_i.v.neg ? -$signed({1'b0, res_i.v.quo}) : $signed({1'b0, res_i.v.quo});
    w_s   = $signed((QB+1)'(w_i));
    h_s   = $signed((QB+1)'(h_i));
    ru    = ~res_i.u.ovf & ~val_u[QB] & (val_u < w_s);
    rv    = ~res_i.v.ovf & ~val_v[QB] & (val_v < h_s);
    front_d = res_i.front;
    inb_d   = res_i.front & ru & rv;
    pu_d    = res_i.front ? sat_pix(res_i.u.ovf, res_i.u.neg, val_u) : '0;
    pv_d    = res_i.front ? sat_pix(res_i.v.ovf, res_i.v.neg, val_v) : '0;
    col_d   = val_u[DIM_W-1:0];
    row_d   = h_i - DIM_W'(1) - val_v[DIM_W-1:0];
    idx_d   = inb_q ? IDX_W'((2*DIM_W)'(row_q) * (2*DIM_W)'(w_i) + (2*DIM_W)'(col_q)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_q <= front_d;
      inb_q   <= inb_d;
      pu_q    <= pu_d;
      pv_q    <= pv_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
    if (en[1]) begin
      in_front_o    <= front_q;
      in_bounds_o   <= inb_q;
      pixel_u_o     <= pu_q;
      pixel_v_o     <= pv_q;
      texel_index_o <= idx_d;
    end
  end

endmodule
